@@ rtl/ipp_pkg.sv @@
package ipp_pkg;

    localparam int SCREEN_BYTES_DEF  = 16384;
    localparam int BYTES_PER_ROW_DEF = 80;

    localparam logic [15:0] SCREEN_BASE  = 16'hC000;
    localparam logic [8:0]  X_MAX_MODE0  = 9'd159;
    localparam logic [8:0]  X_MAX_MODE1  = 9'd319;
    localparam logic [7:0]  Y_MAX        = 8'd199;

    localparam logic OP_PLOT = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic MODE_2PIX = 1'b0;
    localparam logic MODE_4PIX = 1'b1;

    // decoded request, held while the memory access is in flight
    typedef struct packed {
        logic       opcode;
        logic       oor;
        logic       mode;
        logic [1:0] pix;
        logic [3:0] pen;
    } ipp_req_t;

endpackage

@@ rtl/interleaved_pixel_plotter.sv @@
// Interleaved pixel plotter: 16 KiB screen store with pixel plot and byte read.
// Input channel (in_valid/in_stall) carries one word: opcode, x, y, color.
// Output channel (out_valid/out_stall) returns one word per input word:
// byte_address (0xC000 + interleaved offset), byte_value, out_of_range.
// cfg_wr_en/cfg_wr_data set video_mode (0: 2 pixels/byte, 1: 4 pixels/byte);
// write it only while no word is in flight.
// Each word passes through decode and register, memory read (synchronous
// read port), then merge and write back into the same memory; the result is
// registered at the merge, and a new word is taken only once the last leaves it.
// Out-of-range coordinates write nothing and return 0xC000, 0, flag set.
// After reset the screen memory is swept to zero, one byte per cycle;
// in_stall stays high during the sweep.
// A stalled result holds in the output register; the next input word is still
// taken and waits at the merge step until the output register frees up.
module interleaved_pixel_plotter
    import ipp_pkg::*;
#(
    parameter int SCREEN_BYTES  = SCREEN_BYTES_DEF,
    parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [8:0]  x,
    input  logic [7:0]  y,
    input  logic [3:0]  color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] byte_address,
    output logic [7:0]  byte_value,
    output logic        out_of_range
);

    localparam int AW = $clog2(SCREEN_BYTES);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_MERGE = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic          mode_reg;
    ipp_req_t      req_reg;
    logic [AW-1:0] offset_reg;

    ipp_req_t      req_calc;
    logic [AW-1:0] offset_calc;

    logic          out_valid_reg;
    logic [15:0]   addr_out_reg;
    logic [7:0]    value_out_reg;
    logic          oor_out_reg;

    logic          clear_busy;
    logic [7:0]    rd_data;
    logic [7:0]    new_byte;
    logic          in_take;
    logic          out_free;
    logic          merge_done;

    function automatic logic [7:0] merge_pixel(input logic [7:0] old, input ipp_req_t r);
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        b  = old;
        hi = 8'h80 >> r.pix;
        lo = 8'h08 >> r.pix;
        if (r.mode == MODE_4PIX)
        begin
            b = b & ~(hi | lo);
            if (r.pen[0]) b = b | hi;
            if (r.pen[1]) b = b | lo;
        end
        else if (r.pix[0] == 1'b0)
        begin
            // even pixel: pen bits 0..3 to byte bits 7,3,5,1
            b = (b & 8'h55) | {r.pen[0], 1'b0, r.pen[2], 1'b0, r.pen[1], 1'b0, r.pen[3], 1'b0};
        end
        else
        begin
            // odd pixel: pen bits 0..3 to byte bits 6,2,4,0
            b = (b & 8'hAA) | {1'b0, r.pen[0], 1'b0, r.pen[2], 1'b0, r.pen[1], 1'b0, r.pen[3]};
        end
        return b;
    endfunction

    ipp_addr_calc #(
        .SCREEN_BYTES  (SCREEN_BYTES),
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_addr_calc (
        .mode   (mode_reg),
        .opcode (opcode),
        .x      (x),
        .y      (y),
        .color  (color),
        .req    (req_calc),
        .offset (offset_calc)
    );

    ipp_screen_mem #(
        .SCREEN_BYTES (SCREEN_BYTES)
    ) u_screen_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (state_reg == S_READ),
        .rd_addr    (offset_reg),
        .rd_data    (rd_data),
        .wr_en      (merge_done && (req_reg.opcode == OP_PLOT) && !req_reg.oor),
        .wr_addr    (offset_reg),
        .wr_data    (new_byte),
        .clear_busy (clear_busy)
    );

    assign in_stall   = (state_reg != S_IDLE) || clear_busy;
    assign in_take    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign merge_done = (state_reg == S_MERGE) && out_free;
    assign new_byte   = (req_reg.opcode == OP_PLOT) ? merge_pixel(rd_data, req_reg) : rd_data;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take) state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (out_free) state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_2PIX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (merge_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg    <= req_calc;
            offset_reg <= offset_calc;
        end
        if (merge_done)
        begin
            oor_out_reg <= req_reg.oor;
            if (req_reg.oor)
            begin
                addr_out_reg  <= SCREEN_BASE;
                value_out_reg <= 8'h00;
            end
            else
            begin
                addr_out_reg  <= SCREEN_BASE + 16'(offset_reg);
                value_out_reg <= new_byte;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_address = addr_out_reg;
    assign byte_value   = value_out_reg;
    assign out_of_range = oor_out_reg;

endmodule

@@ rtl/ipp_addr_calc.sv @@
module ipp_addr_calc
    import ipp_pkg::*;
#(
    parameter int SCREEN_BYTES  = SCREEN_BYTES_DEF,
    parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF
)
(
    input  logic                            mode,
    input  logic                            opcode,
    input  logic [8:0]                      x,
    input  logic [7:0]                      y,
    input  logic [3:0]                      color,
    output ipp_req_t                        req,
    output logic [$clog2(SCREEN_BYTES)-1:0] offset
);

    localparam int AW          = $clog2(SCREEN_BYTES);
    localparam int LINE_STRIDE = SCREEN_BYTES / 8;

    logic [8:0]  x_max;
    logic [7:0]  col;
    logic [15:0] sum;

    always_comb
    begin
        x_max = (mode == MODE_4PIX) ? X_MAX_MODE1 : X_MAX_MODE0;
        col   = (mode == MODE_4PIX) ? 8'(x >> 2) : 8'(x >> 1);

        // character row * row pitch + scan line * line stride + column
        sum = 16'(16'(y[7:3]) * 16'(BYTES_PER_ROW))
            + 16'(16'(y[2:0]) * 16'(LINE_STRIDE))
            + 16'(col);
        offset = sum[AW-1:0];

        req.opcode = opcode;
        req.oor    = (x > x_max) || (y > Y_MAX);
        req.mode   = mode;
        req.pix    = (mode == MODE_4PIX) ? x[1:0] : {1'b0, x[0]};
        req.pen    = (mode == MODE_4PIX) ? {2'b00, color[1:0]} : color;
    end

endmodule

@@ rtl/ipp_screen_mem.sv @@
module ipp_screen_mem
    import ipp_pkg::*;
#(
    parameter int SCREEN_BYTES = SCREEN_BYTES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [$clog2(SCREEN_BYTES)-1:0] rd_addr,
    output logic [7:0]                      rd_data,
    input  logic                            wr_en,
    input  logic [$clog2(SCREEN_BYTES)-1:0] wr_addr,
    input  logic [7:0]                      wr_data,
    output logic                            clear_busy
);

    localparam int AW = $clog2(SCREEN_BYTES);

    logic [7:0]    mem [SCREEN_BYTES];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_busy_reg;

    logic          we;
    logic [AW-1:0] wa;
    logic [7:0]    wd;

    // clearing pass owns the write port after reset
    always_comb
    begin
        if (clr_busy_reg)
        begin
            we = 1'b1;
            wa = clr_cnt_reg;
            wd = 8'h00;
        end
        else
        begin
            we = wr_en;
            wa = wr_addr;
            wd = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {AW{1'b1}})
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule
